[rtl/imhq_pkg.sv]
// shared types and constants for the indexed min-heap queue
package imhq_pkg;

  localparam int unsigned NodeW  = 10;
  localparam int unsigned Nodes  = 1 << NodeW;
  localparam int unsigned SlotW  = NodeW + 1;
  localparam int unsigned KeyW   = 32;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_EXTRACT  = 2'd1,
    CMD_DECREASE = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_FULL       = 3'd2,
    ST_QUEUED     = 3'd3,
    ST_NOT_QUEUED = 3'd4,
    ST_NOT_SMALLER = 3'd5
  } status_e;

  typedef logic [NodeW-1:0] node_t;
  typedef logic [SlotW-1:0] slot_t;
  typedef logic [KeyW-1:0]  key_t;

endpackage

[rtl/imhq_ram.sv]
// single-port synchronous ram with registered read data
module imhq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

[rtl/indexed_min_heap_queue.sv]
// indexed binary min-heap priority queue with insert, extract and decrease key
// One command is taken at a time. in_stall_o stays high until that command's single result
// has been transferred. A command runs a small sequencer over three single-port memories
// (slot to node, node to key, node to slot). Each sift-up level does memory reads, one key
// compare and the swap writes; a sift-down level also compares the two children first.
// After reset a clearing pass marks every node as not queued before the first command
// is taken.
module indexed_min_heap_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [9:0]  node_i,
  input  logic [31:0] key_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [9:0]  out_node_o,
  output logic [31:0] out_key_o,
  output logic [2:0]  status_o,
  output logic [10:0] occupancy_o
);

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_CHK0  = 5'd2;
  localparam logic [4:0] S_CHK1  = 5'd3;
  localparam logic [4:0] S_CHK2  = 5'd4;
  localparam logic [4:0] S_UP0   = 5'd5;
  localparam logic [4:0] S_UP1   = 5'd6;
  localparam logic [4:0] S_UP2   = 5'd7;
  localparam logic [4:0] S_UP3   = 5'd8;
  localparam logic [4:0] S_SWAP0 = 5'd9;
  localparam logic [4:0] S_SWAP1 = 5'd10;
  localparam logic [4:0] S_SWAP2 = 5'd11;
  localparam logic [4:0] S_SWAP3 = 5'd12;
  localparam logic [4:0] S_EX0   = 5'd13;
  localparam logic [4:0] S_EX1   = 5'd14;
  localparam logic [4:0] S_EX2   = 5'd15;
  localparam logic [4:0] S_EX3   = 5'd16;
  localparam logic [4:0] S_DN0   = 5'd17;
  localparam logic [4:0] S_DN1   = 5'd18;
  localparam logic [4:0] S_DN2   = 5'd19;
  localparam logic [4:0] S_DN3   = 5'd20;
  localparam logic [4:0] S_DN4   = 5'd21;
  localparam logic [4:0] S_DN5   = 5'd22;
  localparam logic [4:0] S_OUT   = 5'd23;
  localparam logic [4:0] S_INS0  = 5'd24;

  localparam int unsigned NW = imhq_pkg::NodeW;
  localparam int unsigned SW = imhq_pkg::SlotW;
  localparam imhq_pkg::slot_t NotQueued = imhq_pkg::slot_t'(imhq_pkg::Nodes);

  logic [4:0] state_q, state_d;
  imhq_pkg::cmd_e  cmd_q, cmd_d;
  imhq_pkg::node_t node_q, node_d;
  imhq_pkg::key_t  key_q, key_d;
  imhq_pkg::slot_t cnt_q, cnt_d;
  // cur/other: slots being compared; nc/no: their nodes; kc/ko: their keys
  imhq_pkg::slot_t cur_q, cur_d, oth_q, oth_d;
  imhq_pkg::node_t nc_q, nc_d, no_q, no_d, nl_q, nl_d;
  imhq_pkg::key_t  kc_q, kc_d, ko_q, ko_d, kl_q, kl_d;
  logic out_valid_q, out_valid_d;
  imhq_pkg::node_t onode_q, onode_d;
  imhq_pkg::key_t  okey_q, okey_d;
  imhq_pkg::status_e ost_q, ost_d;

  // memory ports
  logic hs_we, nk_we, sn_we;
  imhq_pkg::node_t hs_a, nk_a, sn_a;
  imhq_pkg::node_t hs_wd, hs_rd;
  imhq_pkg::key_t  nk_wd, nk_rd;
  imhq_pkg::slot_t sn_wd, sn_rd;

  imhq_ram #(.Width(NW), .Depth(imhq_pkg::Nodes)) u_heap (
    .clk_i, .we_i(hs_we), .addr_i(hs_a), .wdata_i(hs_wd), .rdata_o(hs_rd));
  imhq_ram #(.Width(imhq_pkg::KeyW), .Depth(imhq_pkg::Nodes)) u_key (
    .clk_i, .we_i(nk_we), .addr_i(nk_a), .wdata_i(nk_wd), .rdata_o(nk_rd));
  imhq_ram #(.Width(SW), .Depth(imhq_pkg::Nodes)) u_map (
    .clk_i, .we_i(sn_we), .addr_i(sn_a), .wdata_i(sn_wd), .rdata_o(sn_rd));

  // compare unit for the sift-down decision
  logic kgt;
  assign kgt = ko_q > kc_q;

  imhq_pkg::slot_t left_s, par_s;
  assign left_s = imhq_pkg::slot_t'({cur_q[SW-2:0], 1'b1});
  assign par_s  = (cur_q - imhq_pkg::slot_t'(1)) >> 1;

  always_comb begin
    state_d = state_q; cmd_d = cmd_q; node_d = node_q; key_d = key_q; cnt_d = cnt_q;
    cur_d = cur_q; oth_d = oth_q; nc_d = nc_q; no_d = no_q; nl_d = nl_q;
    kc_d = kc_q; ko_d = ko_q; kl_d = kl_q;
    out_valid_d = out_valid_q; onode_d = onode_q; okey_d = okey_q; ost_d = ost_q;
    hs_we = 1'b0; nk_we = 1'b0; sn_we = 1'b0;
    hs_a = '0; nk_a = node_q; sn_a = node_q;
    hs_wd = '0; nk_wd = key_q; sn_wd = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_CLEAR: begin
        sn_we = 1'b1; sn_a = cur_q[NW-1:0]; sn_wd = NotQueued;
        cur_d = cur_q + 1'b1;
        if (cur_q[NW-1:0] == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i && !out_valid_q) begin
          cmd_d = imhq_pkg::cmd_e'(command_i);
          node_d = node_i; key_d = key_i;
          onode_d = '0; okey_d = '0; ost_d = imhq_pkg::ST_OK;
          state_d = S_CHK0;
        end
      end
      S_CHK0: begin
        sn_a = node_q; nk_a = node_q; state_d = S_CHK1;
      end
      S_CHK1: begin
        state_d = S_OUT;
        case (cmd_q)
          imhq_pkg::CMD_INSERT: begin
            if (cnt_q == imhq_pkg::slot_t'(imhq_pkg::Nodes)) begin
              ost_d = imhq_pkg::ST_FULL;
            end else if (sn_rd != NotQueued) begin
              ost_d = imhq_pkg::ST_QUEUED;
            end else begin
              nk_we = 1'b1; nk_a = node_q; nk_wd = key_q;
              hs_we = 1'b1; hs_a = cnt_q[NW-1:0]; hs_wd = node_q;
              state_d = S_INS0;
            end
          end
          imhq_pkg::CMD_EXTRACT: begin
            if (cnt_q == '0) begin
              ost_d = imhq_pkg::ST_EMPTY;
            end else begin
              hs_a = '0; state_d = S_EX0;
            end
          end
          imhq_pkg::CMD_DECREASE: begin
            if (sn_rd >= cnt_q) begin
              ost_d = imhq_pkg::ST_NOT_QUEUED;
            end else if (!(key_q < nk_rd)) begin
              ost_d = imhq_pkg::ST_NOT_SMALLER;
            end else begin
              nk_we = 1'b1; nk_a = node_q; nk_wd = key_q;
              cur_d = sn_rd; nc_d = node_q; kc_d = key_q;
              state_d = S_UP0;
            end
          end
          default: ;
        endcase
      end
      S_INS0: begin
        sn_we = 1'b1; sn_a = node_q; sn_wd = cnt_q;
        cur_d = cnt_q; nc_d = node_q; kc_d = key_q;
        cnt_d = cnt_q + 1'b1;
        state_d = S_UP0;
      end
      // sift up: node nc at slot cur with key kc
      S_UP0: begin
        if (cur_q == '0) begin
          state_d = S_OUT;
        end else begin
          oth_d = par_s; hs_a = par_s[NW-1:0]; state_d = S_UP1;
        end
      end
      S_UP1: begin
        hs_a = oth_q[NW-1:0]; state_d = S_UP2;
      end
      S_UP2: begin
        no_d = hs_rd; nk_a = hs_rd; state_d = S_UP3;
      end
      S_UP3: begin
        nk_a = no_q; state_d = S_CHK2;
      end
      S_CHK2: begin
        ko_d = nk_rd;
        if (nk_rd > kc_q) begin
          state_d = S_SWAP0;
        end else begin
          state_d = S_OUT;
        end
      end
      // swap slot cur (node nc) with slot oth (node no); node nc moves to oth
      S_SWAP0: begin
        hs_we = 1'b1; hs_a = cur_q[NW-1:0]; hs_wd = no_q; state_d = S_SWAP1;
      end
      S_SWAP1: begin
        hs_we = 1'b1; hs_a = oth_q[NW-1:0]; hs_wd = nc_q; state_d = S_SWAP2;
      end
      S_SWAP2: begin
        sn_we = 1'b1; sn_a = no_q; sn_wd = cur_q; state_d = S_SWAP3;
      end
      S_SWAP3: begin
        sn_we = 1'b1; sn_a = nc_q; sn_wd = oth_q;
        cur_d = oth_q;
        state_d = (cmd_q == imhq_pkg::CMD_EXTRACT) ? S_DN0 : S_UP0;
      end
      S_EX0: begin
        state_d = S_EX1;
      end
      S_EX1: begin
        onode_d = hs_rd; nk_a = hs_rd; node_d = hs_rd;
        hs_a = cnt_q[NW-1:0] - 1'b1;
        cnt_d = cnt_q - 1'b1;
        state_d = S_EX2;
      end
      S_EX2: begin
        okey_d = nk_rd;
        sn_we = 1'b1; sn_a = node_q; sn_wd = NotQueued;
        nc_d = hs_rd; nk_a = hs_rd;
        state_d = (cnt_q == '0) ? S_OUT : S_EX3;
      end
      S_EX3: begin
        kc_d = nk_rd;
        hs_we = 1'b1; hs_a = '0; hs_wd = nc_q;
        sn_we = 1'b1; sn_a = nc_q; sn_wd = '0;
        cur_d = '0;
        state_d = S_DN0;
      end
      // sift down: node nc at slot cur with key kc
      S_DN0: begin
        if (left_s >= cnt_q || cur_q[SW-1]) begin
          state_d = S_OUT;
        end else begin
          oth_d = left_s; hs_a = left_s[NW-1:0]; state_d = S_DN1;
        end
      end
      S_DN1: begin
        nl_d = hs_rd; nk_a = hs_rd;
        hs_a = left_s[NW-1:0] + 1'b1; state_d = S_DN2;
      end
      S_DN2: begin
        no_d = hs_rd; nk_a = hs_rd; kl_d = nk_rd; state_d = S_DN3;
      end
      S_DN3: begin
        nk_a = no_q; state_d = S_DN4;
      end
      S_DN4: begin
        nk_a = no_q; state_d = S_DN5;
      end
      S_DN5: begin
        // right child wins unless strictly larger than left
        if ((left_s + 1'b1) < cnt_q && !(nk_rd > kl_q)) begin
          oth_d = left_s + 1'b1; ko_d = nk_rd;
        end else begin
          no_d = nl_q; ko_d = kl_q;
        end
        state_d = S_CHK2;
        kc_d = kc_q;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // down path reuses compare state with swapped roles
    if (state_q == S_CHK2 && cmd_q == imhq_pkg::CMD_EXTRACT) begin
      ko_d = ko_q;
      state_d = kgt ? S_OUT : (ko_q == kc_q ? S_OUT : S_SWAP0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; cnt_q <= '0; cur_q <= '0; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; cur_q <= cur_d; out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; node_q <= node_d; key_q <= key_d;
    oth_q <= oth_d; nc_q <= nc_d; no_q <= no_d; nl_q <= nl_d;
    kc_q <= kc_d; ko_q <= ko_d; kl_q <= kl_d;
    onode_q <= onode_d; okey_q <= okey_d; ost_q <= ost_d;
  end

  assign in_stall_o  = (state_q != S_IDLE) || out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_node_o  = onode_q;
  assign out_key_o   = okey_q;
  assign status_o    = ost_q;
  assign occupancy_o = cnt_q;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= imhq_pkg::slot_t'(imhq_pkg::Nodes)) else $error("count out of range");
  a_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && !(out_valid_q && out_stall_i)) |=> out_valid_q)
    else $error("result not presented");
  a_err_nochg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_d && !out_valid_q && ost_q != imhq_pkg::ST_OK) |=> $stable(cnt_q))
    else $error("error changed count");
`endif

endmodule

[tb/sv/tb_top.sv]
// testbench for the indexed min-heap queue: random and directed commands checked against a heap model
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  class heap_scoreboard;
    imhq_pkg::node_t   slots [imhq_pkg::Nodes];
    imhq_pkg::slot_t   slot_of [imhq_pkg::Nodes];
    imhq_pkg::key_t    keys [imhq_pkg::Nodes];
    int unsigned count;
    logic [55:0] pending [$];
    int errors;

    function new();
      for (int i = 0; i < imhq_pkg::Nodes; i++) begin
        slot_of[i] = imhq_pkg::slot_t'(imhq_pkg::Nodes);
        slots[i] = '0;
        keys[i] = '0;
      end
      count = 0;
      errors = 0;
    endfunction

    function void swap_at(int unsigned a, int unsigned b);
      imhq_pkg::node_t na;
      imhq_pkg::node_t nb;
      na = slots[a];
      nb = slots[b];
      slots[a] = nb;
      slots[b] = na;
      slot_of[nb] = imhq_pkg::slot_t'(a);
      slot_of[na] = imhq_pkg::slot_t'(b);
    endfunction

    function void bubble_up(int unsigned i);
      int unsigned p;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (keys[slots[p]] > keys[slots[i]]) begin
          swap_at(p, i);
          i = p;
        end else break;
      end
    endfunction

    function void bubble_down(int unsigned i);
      int unsigned l;
      int unsigned m;
      forever begin
        l = 2 * i + 1;
        if (l >= count) break;
        m = l;
        if (l + 1 < count && !(keys[slots[l+1]] > keys[slots[l]])) m = l + 1;
        if (keys[slots[i]] > keys[slots[m]]) begin
          swap_at(i, m);
          i = m;
        end else break;
      end
    endfunction

    function void note_command(imhq_pkg::cmd_e c, imhq_pkg::node_t n, imhq_pkg::key_t k);
      imhq_pkg::node_t   rn;
      imhq_pkg::key_t    rk;
      imhq_pkg::status_e st;
      imhq_pkg::slot_t   s;
      rn = '0;
      rk = '0;
      st = imhq_pkg::ST_OK;
      case (c)
        imhq_pkg::CMD_INSERT: begin
          if (count >= imhq_pkg::Nodes) st = imhq_pkg::ST_FULL;
          else if (slot_of[n] != imhq_pkg::slot_t'(imhq_pkg::Nodes)) st = imhq_pkg::ST_QUEUED;
          else begin
            keys[n] = k;
            slots[count] = n;
            slot_of[n] = imhq_pkg::slot_t'(count);
            count++;
            bubble_up(count - 1);
          end
        end
        imhq_pkg::CMD_EXTRACT: begin
          if (count == 0) st = imhq_pkg::ST_EMPTY;
          else begin
            rn = slots[0];
            rk = keys[rn];
            slot_of[rn] = imhq_pkg::slot_t'(imhq_pkg::Nodes);
            count--;
            if (count > 0) begin
              slots[0] = slots[count];
              slot_of[slots[0]] = '0;
              bubble_down(0);
            end
          end
        end
        imhq_pkg::CMD_DECREASE: begin
          s = slot_of[n];
          if (s >= count) st = imhq_pkg::ST_NOT_QUEUED;
          else if (!(k < keys[n])) st = imhq_pkg::ST_NOT_SMALLER;
          else begin
            keys[n] = k;
            bubble_up(s);
          end
        end
        default: ;
      endcase
      pending.push_back({rn, rk, st, 11'(count)});
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(imhq_pkg::node_t n, imhq_pkg::key_t k, logic [2:0] st,
                      logic [10:0] occ);
      logic [55:0] e;
      if (pending.size() == 0) begin
        report("result with nothing pending");
        return;
      end
      e = pending.pop_front();
      if (n !== e[55:46]) report($sformatf("out_node %0d exp %0d", n, e[55:46]));
      if (k !== e[45:14]) report($sformatf("out_key %0d exp %0d", k, e[45:14]));
      if (st !== e[13:11]) report($sformatf("status %0d exp %0d", st, e[13:11]));
      if (occ !== e[10:0]) report($sformatf("occupancy %0d exp %0d", occ, e[10:0]));
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  logic [1:0] command_i = '0;
  logic [9:0] node_i = '0;
  logic [31:0] key_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  logic [9:0] out_node_o;
  logic [31:0] out_key_o;
  logic [2:0] status_o;
  logic [10:0] occupancy_o;

  heap_scoreboard sb = new();
  int cycles = 0;
  int sent = 0;
  int got = 0;

  indexed_min_heap_queue dut (.*);

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // check each transferred result; receiver stall pattern with quiet stretches
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      sb.check_result(out_node_o, out_key_o, status_o, occupancy_o);
      got++;
    end
    if ((cycles / 700) % 3 == 0) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 3) == 0);
  end

  task automatic push_cmd(logic [1:0] c, logic [9:0] n, logic [31:0] k);
    in_valid_i <= 1'b1;
    command_i <= c;
    node_i <= n;
    key_i <= k;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_command(imhq_pkg::cmd_e'(c), n, k);
    sent++;
  endtask

  task automatic go_idle(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  initial begin
    int burst;
    int r;
    logic [1:0] c;
    logic [9:0] n;
    logic [31:0] k;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: empty extract, extremes, ties, errors, unused command
    push_cmd(imhq_pkg::CMD_EXTRACT, 10'h3ff, '1);
    push_cmd(imhq_pkg::CMD_DECREASE, 10'd5, 32'd1);
    push_cmd(imhq_pkg::CMD_INSERT, 10'd0, 32'hffffffff);
    push_cmd(imhq_pkg::CMD_INSERT, 10'h3ff, 32'd0);
    push_cmd(imhq_pkg::CMD_INSERT, 10'h3ff, 32'd7);
    push_cmd(imhq_pkg::CMD_INSERT, 10'd1, 32'd50);
    push_cmd(imhq_pkg::CMD_INSERT, 10'd2, 32'd50);
    push_cmd(imhq_pkg::CMD_INSERT, 10'd3, 32'd50);
    push_cmd(imhq_pkg::CMD_DECREASE, 10'd1, 32'd50);
    push_cmd(imhq_pkg::CMD_DECREASE, 10'd1, 32'd60);
    push_cmd(imhq_pkg::CMD_DECREASE, 10'd0, 32'd0);
    push_cmd(imhq_pkg::CMD_NOP, 10'h2aa, 32'h55555555);
    push_cmd(imhq_pkg::CMD_DECREASE, 10'd3, 32'd49);
    repeat (7) push_cmd(imhq_pkg::CMD_EXTRACT, 10'd0, '0);
    // fill to full once, then drain part of it, to hit the full cases
    for (int i = 0; i < imhq_pkg::Nodes; i++) begin
      push_cmd(imhq_pkg::CMD_INSERT, 10'(i), $urandom_range(0, 20));
    end
    push_cmd(imhq_pkg::CMD_INSERT, 10'd9, 32'd1);
    push_cmd(imhq_pkg::CMD_INSERT, 10'd9, 32'd1);
    for (int i = 0; i < 256; i++) push_cmd(imhq_pkg::CMD_EXTRACT, 10'(i), '0);
    while (sent < 1500) begin
      burst = $urandom_range(1, 30);
      repeat (burst) begin
        r = $urandom_range(0, 99);
        k = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 15);
        n = 10'($urandom);
        if (r < 45) c = imhq_pkg::CMD_INSERT;
        else if (r < 75) c = imhq_pkg::CMD_EXTRACT;
        else if (r < 97) begin
          c = imhq_pkg::CMD_DECREASE;
          if (sb.count > 0 && $urandom_range(0, 3) != 0) begin
            n = sb.slots[$urandom_range(0, sb.count - 1)];
            k = (sb.keys[n] == 0) ? 0 : $urandom_range(0, sb.keys[n]);
          end
        end else c = imhq_pkg::CMD_NOP;
        push_cmd(c, n, k);
      end
      go_idle($urandom_range(1, 8));
    end
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("ran %0d commands, %0d results, including a fill to full and partial drain",
             sent, got);
    if (sb.errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end
endmodule
